>>> rtl/dertlv_pkg.sv
// Shared types and codes for the DER TLV header parser.
package dertlv_pkg;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_EOF  = 2'd1,
		ST_FF   = 2'd2,
		ST_LONG = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_TAGEXT = 4'b0010,
		PH_LEN1   = 4'b0100,
		PH_LENX   = 4'b1000
	} phase_t;

	localparam logic [4:0] TAG_ESCAPE   = 5'h1f;
	localparam logic [7:0] LEN_RESERVED = 8'hff;

	typedef struct packed {
		logic [2:0]  header_bytes;
		logic [31:0] content_length;
		logic [6:0]  tag_number;
		logic        long_form_tag;
		logic        constructed;
		logic [1:0]  id_class;
		status_t     status;
	} result_t;

endpackage

>>> rtl/dertlv_core.sv
// Header decode state and per-beat next-state logic.
module dertlv_core
	import dertlv_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        start_flag,
	input  logic [31:0] avail_bytes,
	output logic        res_valid,
	output result_t     res
);

	localparam int TOGO_W = $clog2(MAX_LENGTH_BYTES + 1);
	localparam logic [6:0] MAX_N = 7'(MAX_LENGTH_BYTES);

	phase_t            phase_q, phase_d;
	logic [31:0]       left_q, left_d;
	logic [31:0]       acc_q, acc_d;
	logic [TOGO_W-1:0] togo_q, togo_d;
	logic [1:0]        class_q, class_d;
	logic              cons_q, cons_d;
	logic [6:0]        tag_q, tag_d;
	logic              ltag_q, ltag_d;
	logic [2:0]        hcnt_q, hcnt_d;

	logic              emit;
	status_t           emit_st;
	logic [31:0]       emit_len;
	logic [6:0]        len_n;

	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		acc_d    = acc_q;
		togo_d   = togo_q;
		class_d  = class_q;
		cons_d   = cons_q;
		tag_d    = tag_q;
		ltag_d   = ltag_q;
		hcnt_d   = hcnt_q;
		emit     = 1'b0;
		emit_st  = ST_OK;
		emit_len = 32'd0;
		len_n    = data_byte[6:0];

		if (start_flag) begin
			// new element: drop whatever was in flight
			acc_d   = 32'd0;
			togo_d  = '0;
			ltag_d  = 1'b0;
			left_d  = avail_bytes;
			if (avail_bytes == 32'd0) begin
				class_d = 2'd0;
				cons_d  = 1'b0;
				tag_d   = 7'd0;
				hcnt_d  = 3'd0;
				emit    = 1'b1;
				emit_st = ST_EOF;
			end else begin
				left_d  = avail_bytes - 32'd1;
				hcnt_d  = 3'd1;
				class_d = data_byte[7:6];
				cons_d  = data_byte[5];
				tag_d   = {2'b00, data_byte[4:0]};
				if (data_byte[4:0] == TAG_ESCAPE) begin
					ltag_d  = 1'b1;
					phase_d = PH_TAGEXT;
				end else begin
					phase_d = PH_LEN1;
				end
			end
		end else if (phase_q != PH_IDLE) begin
			if (left_q == 32'd0) begin
				emit    = 1'b1;
				emit_st = ST_EOF;
			end else begin
				left_d = left_q - 32'd1;
				hcnt_d = hcnt_q + 3'd1;
				case (phase_q)
					PH_TAGEXT: begin
						tag_d   = data_byte[6:0];
						phase_d = PH_LEN1;
					end
					PH_LEN1: begin
						if (!data_byte[7]) begin
							acc_d = {24'd0, data_byte};
							emit  = 1'b1;
						end else if (data_byte == LEN_RESERVED) begin
							emit    = 1'b1;
							emit_st = ST_FF;
						end else if (len_n > MAX_N) begin
							emit    = 1'b1;
							emit_st = ST_LONG;
						end else begin
							acc_d = 32'd0;
							if (len_n == 7'd0) begin
								emit = 1'b1;
							end else begin
								togo_d  = TOGO_W'(len_n);
								phase_d = PH_LENX;
							end
						end
					end
					PH_LENX: begin
						acc_d  = {acc_q[23:0], data_byte};
						togo_d = togo_q - TOGO_W'(1);
						if (togo_q == TOGO_W'(1)) begin
							emit = 1'b1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
				// length decoded: check it against what is left
				if (emit && emit_st == ST_OK) begin
					emit_len = acc_d;
					if (acc_d > left_d) begin
						emit_st = ST_EOF;
					end
				end
			end
		end

		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	assign res_valid          = step && emit;
	assign res.status         = emit_st;
	assign res.id_class       = class_d;
	assign res.constructed    = cons_d;
	assign res.long_form_tag  = ltag_d;
	assign res.tag_number     = tag_d;
	assign res.content_length = emit_len;
	assign res.header_bytes   = hcnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			left_q  <= 32'd0;
			acc_q   <= 32'd0;
			togo_q  <= '0;
			class_q <= 2'd0;
			cons_q  <= 1'b0;
			tag_q   <= 7'd0;
			ltag_q  <= 1'b0;
			hcnt_q  <= 3'd0;
		end else if (step) begin
			phase_q <= phase_d;
			left_q  <= left_d;
			acc_q   <= acc_d;
			togo_q  <= togo_d;
			class_q <= class_d;
			cons_q  <= cons_d;
			tag_q   <= tag_d;
			ltag_q  <= ltag_d;
			hcnt_q  <= hcnt_d;
		end
	end

endmodule

>>> rtl/der_tlv_header_parser_top.sv
// Top level of the DER TLV header parser: input stage, decode core, result register.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid / s_tready  s_tdata = data_byte, avail_bytes; s_tuser = start_flag
//  m_*      out  m_tvalid / m_tready  m_tdata = status .. header_bytes (48 bits)
//
// One beat per cycle sustained while the output is not stalled. Each beat is held in
// the input stage and decoded there in a single pass into the result register, from
// which the result shows on m_*. The 32-bit bytes-left compare sets the path.
// Reset is asynchronous, active low; it clears the header state to idle.
// An output stall holds the result register and, behind it, the input stage; the
// input stage refills in the cycle the result is taken.
module der_tlv_header_parser_top
	import dertlv_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] data_byte, [39:8] avail_bytes
	input  logic        s_tuser,   // [0] start_flag
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // [1:0] status, [3:2] id_class, [4] constructed,
	                               // [5] long_form_tag, [12:6] tag_number,
	                               // [44:13] content_length, [47:45] header_bytes
);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [31:0] avail_s1;

	// result register
	logic        out_valid_q;
	result_t     out_q;

	logic        step;
	logic        res_valid;
	result_t     res;

	// the stage moves on when the result register is free or being drained
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata[7:0];
			avail_s1 <= s_tdata[39:8];
			start_s1 <= s_tuser;
		end
	end

	dertlv_core #(
		.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.data_byte  (byte_s1),
		.start_flag (start_s1),
		.avail_bytes(avail_s1),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= res_valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

`ifndef SYNTH
	// a fresh result only comes from a beat decoded in the cycle before
	a_result_from_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !$past(out_valid_q) |-> $past(step))
		else $error("result appeared without a decoded beat");

	// length errors never report a length
	a_err_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == ST_FF || out_q.status == ST_LONG)
		|-> out_q.content_length == 32'd0)
		else $error("length error with nonzero content_length");

	// a beat held in the input stage keeps its payload
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !step |=> valid_s1 && $stable(byte_s1) && $stable(start_s1)
		&& $stable(avail_s1))
		else $error("input stage lost a stalled beat");
`endif

endmodule
